@@ hw/rtl/fpit_pkg.sv @@
// shared constants and types for the facet point-inside test
// no dependencies
package fpit_pkg;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned CfgW       = 31;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CoordW     = 33;
  localparam int unsigned RootW      = 32;
  localparam int unsigned RadW       = 2 * RootW;
  localparam int unsigned SqrtStages = RadW / 2;
  localparam int unsigned EdgeW      = 38;
  localparam int unsigned MagW       = 36;
  localparam int unsigned HalfW      = MagW / 2;
  localparam int unsigned ProdW      = 2 * MagW;

  localparam logic signed [EdgeW-1:0] MoveHalf = EdgeW'(64'd50 << FracBits);

  typedef enum logic [CfgIdxW-1:0] {
    RegLength = 3'd0,
    RegWidth  = 3'd1,
    RegRadius = 3'd2,
    RegTipCut = 3'd3,
    RegSector = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [RootW-1:0]  ex1;
    logic              in_len;
    logic              pt_ok;
    logic              root_ok;
    logic              e1_ok;
    logic              e2_ok;
  } root_sb_t;

endpackage

@@ hw/rtl/fpit_isqrt.sv @@
// pipelined floor square root, one result bit per register stage
// depends on fpit_pkg
module fpit_isqrt (
  input  logic                         clk_i,
  input  logic [fpit_pkg::RadW-1:0]    radicand_i,
  output logic [fpit_pkg::RootW-1:0]   root_o
);

  localparam int unsigned N    = fpit_pkg::SqrtStages;
  localparam int unsigned RW   = fpit_pkg::RootW;
  localparam int unsigned NW   = fpit_pkg::RadW;
  localparam int unsigned RemW = RW + 3;

  logic [RemW-1:0] rem_q [N];
  logic [RemW-1:0] rem_d [N];
  logic [RW-1:0]   root_q [N];
  logic [RW-1:0]   root_d [N];
  logic [NW-1:0]   rad_q [N];
  logic [NW-1:0]   rad_d [N];
  logic [RemW-1:0] rin [N];
  logic [RemW-1:0] cur [N];
  logic [RemW-1:0] trial [N];
  logic [RW-1:0]   oin [N];
  logic [NW-1:0]   nin [N];

  always_comb begin
    rin[0] = '0;
    oin[0] = '0;
    nin[0] = radicand_i;
    for (int s = 1; s < N; s++) begin
      rin[s] = rem_q[s-1];
      oin[s] = root_q[s-1];
      nin[s] = rad_q[s-1];
    end
    for (int s = 0; s < N; s++) begin
      cur[s]   = {rin[s][RemW-3:0], nin[s][NW-1 -: 2]};
      trial[s] = {1'b0, oin[s], 2'b01};
      rad_d[s] = {nin[s][NW-3:0], 2'b00};
      if (cur[s] >= trial[s]) begin
        rem_d[s]  = cur[s] - trial[s];
        root_d[s] = {oin[s][RW-2:0], 1'b1};
      end else begin
        rem_d[s]  = cur[s];
        root_d[s] = {oin[s][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < N; s++) begin
      rem_q[s]  <= rem_d[s];
      root_q[s] <= root_d[s];
      rad_q[s]  <= rad_d[s];
    end
  end

  assign root_o = root_q[N-1];

endmodule

@@ hw/rtl/facet_point_inside_test_core.sv @@
// facet point-inside test, top level: config registers and the full pipeline
// depends on fpit_pkg and fpit_isqrt
//
// usage:
//   write facet_length, facet_width, arc_radius, tip_cut and positive_sector
//   through cfg_we_i / cfg_idx_i / cfg_wdata_i while no point is in flight;
//   unknown indexes are ignored
//   a point transfer happens on each rising edge with start_i high; busy_o is
//   always low, so one point can enter every cycle
//   each point gives one result: done_o is high for exactly one cycle, and
//   on_surface_o holds the result in that same cycle
//   the pipeline is the 32-stage square root (one root bit per stage) plus
//   two stages between the input register and the root (squares, root
//   arguments) and seven behind it (edges, band test, magnitudes, partial
//   products, products, signed terms, result)
//   throughput is one point per cycle; results leave in order
//   the receiver cannot stall, so nothing waits inside the block
//   reset clears all valid bits and returns the registers to their defaults
//   (positive_sector 1, all others 0); points in flight are dropped
module facet_point_inside_test_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [31:0]              point_x_i,
  input  logic signed [31:0]              point_y_i,
  output logic                            done_o,
  output logic                            on_surface_o,
  input  logic                            cfg_we_i,
  input  logic [fpit_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fpit_pkg::CfgW-1:0]       cfg_wdata_i
);

  localparam int unsigned N  = fpit_pkg::SqrtStages;
  localparam int unsigned CW = fpit_pkg::CoordW;
  localparam int unsigned EW = fpit_pkg::EdgeW;
  localparam int unsigned MW = fpit_pkg::MagW;
  localparam int unsigned HW = fpit_pkg::HalfW;
  localparam int unsigned PW = fpit_pkg::ProdW;
  localparam int unsigned RW = fpit_pkg::RootW;
  localparam int unsigned NW = fpit_pkg::RadW;

  // configuration
  logic [fpit_pkg::CfgW-1:0] len_q, width_q, radius_q, cut_q;
  logic                      sector_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      width_q  <= '0;
      radius_q <= '0;
      cut_q    <= '0;
      sector_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (fpit_pkg::cfg_reg_e'(cfg_idx_i))
        fpit_pkg::RegLength: len_q    <= cfg_wdata_i;
        fpit_pkg::RegWidth:  width_q  <= cfg_wdata_i;
        fpit_pkg::RegRadius: radius_q <= cfg_wdata_i;
        fpit_pkg::RegTipCut: cut_q    <= cfg_wdata_i;
        fpit_pkg::RegSector: sector_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage a: input capture in half units
  logic          a_vld_q;
  logic [CW-1:0] a_x_q, a_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else         a_vld_q <= start_i & ~busy_o;
  end

  always_ff @(posedge clk_i) begin
    a_x_q <= {point_x_i, 1'b0};
    a_y_q <= {point_y_i, 1'b0};
  end

  // stage b: squares
  logic signed [CW:0] lim;
  logic [CW-1:0]      xabs;
  logic [RW-1:0]      r2, ex1, ex2;
  logic               b_vld_q, b_inside_q;
  logic [NW-1:0]      b_q_q, b_xx_q, b_e1_q, b_e2_q;
  logic [CW-1:0]      b_x_q, b_y_q, b_xabs_q;
  logic [CW:0]        b_lim_q;
  logic [RW-1:0]      b_ex1_q;

  always_comb begin
    lim  = $signed({3'b000, len_q}) - $signed({2'b00, cut_q, 1'b0});
    xabs = a_x_q[CW-1] ? (~a_x_q + CW'(1)) : a_x_q;
    r2   = {radius_q, 1'b0};
    ex1  = sector_q ? lim[RW-1:0] : {1'b0, len_q};
    ex2  = sector_q ? {1'b0, len_q} : lim[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else         b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    b_q_q      <= NW'(r2) * NW'(r2);
    b_xx_q     <= NW'(xabs[RW-1:0]) * NW'(xabs[RW-1:0]);
    b_e1_q     <= NW'(ex1) * NW'(ex1);
    b_e2_q     <= NW'(ex2) * NW'(ex2);
    b_x_q      <= a_x_q;
    b_y_q      <= a_y_q;
    b_xabs_q   <= xabs;
    b_inside_q <= xabs < {2'b00, len_q};
    b_lim_q    <= lim;
    b_ex1_q    <= ex1;
  end

  // stage c: root arguments and presence flags
  logic [NW:0]        d0, d1, d2;
  logic               c_vld_q;
  logic [NW-1:0]      c_n0_q, c_n1_q, c_n2_q;
  fpit_pkg::root_sb_t c_sb_q;

  always_comb begin
    d0 = {1'b0, b_q_q} - {1'b0, b_xx_q};
    d1 = {1'b0, b_q_q} - {1'b0, b_e1_q};
    d2 = {1'b0, b_q_q} - {1'b0, b_e2_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else         c_vld_q <= b_vld_q;
  end

  always_ff @(posedge clk_i) begin
    c_n0_q         <= d0[NW-1:0];
    c_n1_q         <= d1[NW-1:0];
    c_n2_q         <= d2[NW-1:0];
    c_sb_q.x       <= b_x_q;
    c_sb_q.y       <= b_y_q;
    c_sb_q.ex1     <= b_ex1_q;
    c_sb_q.in_len  <= b_inside_q;
    c_sb_q.pt_ok   <= ~b_lim_q[CW] & (b_xabs_q <= b_lim_q[CW-1:0]);
    c_sb_q.root_ok <= ~d0[NW];
    c_sb_q.e1_ok   <= ~(sector_q & b_lim_q[CW]) & ~d1[NW];
    c_sb_q.e2_ok   <= ~(~sector_q & b_lim_q[CW]) & ~d2[NW];
  end

  // square roots with matching sideband delay
  logic [RW-1:0] s0, s1, s2;

  fpit_isqrt u_root_pt (.clk_i(clk_i), .radicand_i(c_n0_q), .root_o(s0));
  fpit_isqrt u_root_e1 (.clk_i(clk_i), .radicand_i(c_n1_q), .root_o(s1));
  fpit_isqrt u_root_e2 (.clk_i(clk_i), .radicand_i(c_n2_q), .root_o(s2));

  logic [N-1:0]       dl_vld_q;
  fpit_pkg::root_sb_t dl_sb_q [N];
  fpit_pkg::root_sb_t sb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dl_vld_q <= '0;
    else         dl_vld_q <= {dl_vld_q[N-2:0], c_vld_q};
  end

  always_ff @(posedge clk_i) begin
    dl_sb_q[0] <= c_sb_q;
    for (int s = 1; s < N; s++) dl_sb_q[s] <= dl_sb_q[s-1];
  end

  assign sb = dl_sb_q[N-1];

  // stage e: edge heights
  logic signed [EW-1:0] r2e, we, b0, b1, b2;
  logic                 e_vld_q, e_lo_ok_q, e_hi_ok_q, e_inside_q, e_e1_ok_q, e_e2_ok_q;
  logic signed [EW-1:0] e_lo_q, e_hi_q, e_y1_q, e_y2_q;
  logic [CW-1:0]        e_x_q, e_y_q;
  logic [RW-1:0]        e_ex1_q;

  always_comb begin
    r2e = $signed(EW'(r2));
    we  = $signed(EW'(width_q));
    b0  = sector_q ? $signed(EW'(s0)) : fpit_pkg::MoveHalf - $signed(EW'(s0));
    b1  = sector_q ? $signed(EW'(s1)) : fpit_pkg::MoveHalf - $signed(EW'(s1));
    b2  = sector_q ? $signed(EW'(s2)) : fpit_pkg::MoveHalf - $signed(EW'(s2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_vld_q <= 1'b0;
    else         e_vld_q <= dl_vld_q[N-1];
  end

  always_ff @(posedge clk_i) begin
    e_lo_q     <= b0 - r2e - we;
    e_hi_q     <= b0 - r2e + we;
    e_y1_q     <= b1 - r2e + we;
    e_y2_q     <= b2 - r2e - we;
    e_lo_ok_q  <= sb.root_ok & (sector_q | sb.pt_ok);
    e_hi_ok_q  <= sb.root_ok & (~sector_q | sb.pt_ok);
    e_inside_q <= sb.in_len;
    e_e1_ok_q  <= sb.e1_ok;
    e_e2_ok_q  <= sb.e2_ok;
    e_x_q      <= sb.x;
    e_y_q      <= sb.y;
    e_ex1_q    <= sb.ex1;
  end

  // stage f: band test and chord operands
  logic signed [EW-1:0] ys, xs, x1s, braw;
  logic                 both, lo_le, y_le_hi, side, chord_ok, end_pos, sd_neg;
  logic                 f_vld_q, f_fix_q, f_pre_q;
  logic signed [EW-1:0] f_a1_q, f_a2_q, f_b2_q;

  always_comb begin
    ys       = $signed({{(EW-CW){e_y_q[CW-1]}}, e_y_q});
    xs       = $signed({{(EW-CW){e_x_q[CW-1]}}, e_x_q});
    both     = e_lo_ok_q & e_hi_ok_q;
    lo_le    = e_lo_q <= ys;
    y_le_hi  = ys <= e_hi_q;
    side     = e_lo_ok_q ? lo_le : (e_hi_ok_q & y_le_hi);
    chord_ok = e_e1_ok_q & e_e2_ok_q & (cut_q != '0);
    end_pos  = ~e_x_q[CW-1] & (e_x_q != '0);
    sd_neg   = end_pos == sector_q;
    x1s      = end_pos ? $signed(EW'(e_ex1_q)) : -$signed(EW'(e_ex1_q));
    braw     = xs - x1s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_vld_q <= 1'b0;
    else         f_vld_q <= e_vld_q;
  end

  always_ff @(posedge clk_i) begin
    f_fix_q <= e_inside_q & both & lo_le & y_le_hi;
    f_pre_q <= e_inside_q & ~both & chord_ok & side;
    f_a1_q  <= e_y1_q - ys;
    f_a2_q  <= e_y1_q - e_y2_q;
    f_b2_q  <= sd_neg ? -braw : braw;
  end

  // stage g: magnitudes
  logic [EW-1:0] a1m, a2m, b2m;
  logic [MW-1:0] g_m1_q, g_m2_q, g_mb_q, g_cm_q;
  logic          g_n1_q, g_n2_q;

  always_comb begin
    a1m = f_a1_q[EW-1] ? EW'(-f_a1_q) : EW'(f_a1_q);
    a2m = f_a2_q[EW-1] ? EW'(-f_a2_q) : EW'(f_a2_q);
    b2m = f_b2_q[EW-1] ? EW'(-f_b2_q) : EW'(f_b2_q);
  end

  always_ff @(posedge clk_i) begin
    g_m1_q <= a1m[MW-1:0];
    g_m2_q <= a2m[MW-1:0];
    g_mb_q <= b2m[MW-1:0];
    g_cm_q <= MW'({cut_q, 1'b0});
    g_n1_q <= f_a1_q[EW-1];
    g_n2_q <= f_a2_q[EW-1] ^ f_b2_q[EW-1];
  end

  // stage h: partial products
  logic [MW-1:0] h_p1_q [4];
  logic [MW-1:0] h_p2_q [4];
  logic          h_n1_q, h_n2_q;

  always_ff @(posedge clk_i) begin
    h_p1_q[0] <= MW'(g_m1_q[HW-1:0])  * MW'(g_cm_q[HW-1:0]);
    h_p1_q[1] <= MW'(g_m1_q[HW-1:0])  * MW'(g_cm_q[MW-1:HW]);
    h_p1_q[2] <= MW'(g_m1_q[MW-1:HW]) * MW'(g_cm_q[HW-1:0]);
    h_p1_q[3] <= MW'(g_m1_q[MW-1:HW]) * MW'(g_cm_q[MW-1:HW]);
    h_p2_q[0] <= MW'(g_m2_q[HW-1:0])  * MW'(g_mb_q[HW-1:0]);
    h_p2_q[1] <= MW'(g_m2_q[HW-1:0])  * MW'(g_mb_q[MW-1:HW]);
    h_p2_q[2] <= MW'(g_m2_q[MW-1:HW]) * MW'(g_mb_q[HW-1:0]);
    h_p2_q[3] <= MW'(g_m2_q[MW-1:HW]) * MW'(g_mb_q[MW-1:HW]);
    h_n1_q    <= g_n1_q;
    h_n2_q    <= g_n2_q;
  end

  // stage i: full products
  logic [PW-1:0] i_p1_q, i_p2_q;
  logic          i_n1_q, i_n2_q;

  always_ff @(posedge clk_i) begin
    i_p1_q <= PW'(h_p1_q[0]) + (PW'(h_p1_q[1]) << HW) + (PW'(h_p1_q[2]) << HW)
            + (PW'(h_p1_q[3]) << MW);
    i_p2_q <= PW'(h_p2_q[0]) + (PW'(h_p2_q[1]) << HW) + (PW'(h_p2_q[2]) << HW)
            + (PW'(h_p2_q[3]) << MW);
    i_n1_q <= h_n1_q;
    i_n2_q <= h_n2_q;
  end

  // stage j: signed terms
  logic signed [PW:0] j_t1_q, j_t2_q;

  always_ff @(posedge clk_i) begin
    j_t1_q <= i_n1_q ? -$signed({1'b0, i_p1_q}) : $signed({1'b0, i_p1_q});
    j_t2_q <= i_n2_q ? -$signed({1'b0, i_p2_q}) : $signed({1'b0, i_p2_q});
  end

  // sideband through stages g to j
  logic [3:0] t_vld_q, t_fix_q, t_pre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t_vld_q <= '0;
    else         t_vld_q <= {t_vld_q[2:0], f_vld_q};
  end

  always_ff @(posedge clk_i) begin
    t_fix_q <= {t_fix_q[2:0], f_fix_q};
    t_pre_q <= {t_pre_q[2:0], f_pre_q};
  end

  // output stage: chord side and result
  logic signed [PW+1:0] csum;
  logic                 cond;

  always_comb begin
    csum = $signed({j_t1_q[PW], j_t1_q}) + $signed({j_t2_q[PW], j_t2_q});
    cond = sector_q ? ~csum[PW+1] : (csum[PW+1] | (csum == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= t_vld_q[3];
  end

  always_ff @(posedge clk_i) begin
    on_surface_o <= t_fix_q[3] | (t_pre_q[3] & cond);
  end

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##42 done_o)
    else $error("accepted point produced no result");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 42))
    else $error("result without accepted point");

  a_band_chord_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_vld_q[3] |-> !(t_fix_q[3] && t_pre_q[3]))
    else $error("band and chord paths both active");

endmodule
